// File: sv/crc_framed_reply_matcher_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the CRC framed reply matcher
// Concurrent checks on clk with arst_n as the disable condition.
// ----------------------------------------------------------------------------
`ifndef CRC_FRAMED_REPLY_MATCHER_MACROS_SVH
`define CRC_FRAMED_REPLY_MATCHER_MACROS_SVH

`ifndef SYNTHESIS

`define CFRM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define CFRM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define CFRM_ASSERT_IMP(lbl, ante, cons, msg)

`define CFRM_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// File: sv/cfrm_pkg.sv
// ----------------------------------------------------------------------------
// CRC framed reply matcher package
// Transfer types, request and status codes, CRC-16 byte step.
// ----------------------------------------------------------------------------
package cfrm_pkg;

	localparam logic [1:0] REQ_ARM  = 2'd0;
	localparam logic [1:0] REQ_BYTE = 2'd1;
	localparam logic [1:0] REQ_READ = 2'd2;

	localparam logic [1:0] STAT_NONE   = 2'd0;
	localparam logic [1:0] STAT_ACCEPT = 2'd1;
	localparam logic [1:0] STAT_ERROR  = 2'd2;

	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	localparam int MIN_FRAME   = 10;
	localparam int ERR_FRAME   = 11;
	localparam int FN_POS      = 4;
	localparam int ADDR1_POS   = 5;
	localparam int ERRCODE_POS = 6;
	localparam int ADDR3_POS   = 7;
	localparam int ID_LO_BACK  = 4;
	localparam int ID_HI_BACK  = 3;
	localparam logic [3:0] BCD_MAX = 4'd9;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  rx_byte;
		logic        discovery_mode;
		logic [7:0]  expected_fn;
		logic [15:0] expected_id;
		logic [7:0]  read_index;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [8:0]  frame_len;
		logic [7:0]  error_code;
		logic [26:0] meter_address;
		logic [31:0] addr_word;
		logic [7:0]  read_data;
	} rsp_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// File: sv/cfrm_window_ram.sv
// ----------------------------------------------------------------------------
// Receive window memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cfrm_window_ram #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: sv/crc_framed_reply_matcher.sv
// ----------------------------------------------------------------------------
// CRC framed reply matcher
// Collects received bytes in a sliding window and tests the whole window
// for a CRC-16 framed data, error or discovery reply as bytes arrive.
// ----------------------------------------------------------------------------
// Channel   Ports                  Transfer
// request   start, busy, item      rising edge with start high and busy low
// result    done, result           rising edge that ends the cycle done is high
//
// After reset the window memory is zeroed, one entry a cycle, with busy high.
// A byte that leaves a window of MIN_FRAME bytes or more (exactly MIN_FRAME
// in discovery mode) starts a scan: the bytes stream one a cycle from the
// single memory read port through the CRC byte step. Other bytes, arm and
// unused requests give their result in the next cycle. The receiver cannot
// stall: done is high for exactly one cycle per request.
// ----------------------------------------------------------------------------
`include "crc_framed_reply_matcher_macros.svh"

module crc_framed_reply_matcher #(
	parameter int BUF_DEPTH = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  cfrm_pkg::req_t item,
	output logic           busy,
	output logic           done,
	output cfrm_pkg::rsp_t result
);

	localparam int AW = $clog2(BUF_DEPTH);
	localparam int CW = $clog2(BUF_DEPTH + 1);
	localparam logic [AW:0]   DEPTH_W = (AW + 1)'(BUF_DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(BUF_DEPTH);
	localparam logic [AW-1:0] LAST_A  = AW'(BUF_DEPTH - 1);

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_SCAN  = 5'b00100,
		ST_EVAL  = 5'b01000,
		ST_READ  = 5'b10000
	} state_t;

	state_t         state_q;
	logic [AW-1:0]  head_q;
	logic [AW-1:0]  clr_q;
	logic [CW-1:0]  count_q;
	logic [CW-1:0]  n_q;
	logic [CW-1:0]  iss_q;
	logic           mode_q;
	logic [7:0]     fn_q;
	logic [15:0]    id_q;
	logic [15:0]    crc_q;
	logic [7:0]     b4_q, b5_q, b6_q, b7_q, idl_q, idh_q;
	logic [26:0]    acc_q;
	logic           bcd_ok_q;
	logic           rd_ok_q;
	logic           dat_v_s1;
	logic [CW-1:0]  dat_idx_s1;
	logic           done_q;
	cfrm_pkg::rsp_t rsp_q;

	logic           take;
	logic           full;
	logic           idx_ok;
	logic [AW-1:0]  off;
	logic [AW:0]    sum;
	logic [AW-1:0]  phys;
	logic [CW-1:0]  n_new;
	logic           need_scan;
	logic           ram_we;
	logic [AW-1:0]  ram_waddr;
	logic [7:0]     ram_wdata;
	logic [7:0]     ram_rdata;
	logic           last;
	logic [3:0]     dig_hi, dig_lo;
	logic           crc_good;
	logic           err_frame;
	logic           accept;
	logic           done_nx;
	cfrm_pkg::rsp_t rsp_nx;

	assign take   = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = rsp_q;

	assign full   = (count_q == DEPTH_C);
	assign idx_ok = (32'(item.read_index) < 32'(BUF_DEPTH));
	assign n_new  = full ? DEPTH_C : count_q + CW'(1);
	assign need_scan = mode_q ? (n_new == CW'(cfrm_pkg::MIN_FRAME))
	                          : (n_new >= CW'(cfrm_pkg::MIN_FRAME));

	always_comb begin
		if (state_q == ST_SCAN) begin
			off = AW'(iss_q);
		end else if (item.req_type == cfrm_pkg::REQ_READ) begin
			off = AW'(item.read_index);
		end else if (full) begin
			off = '0;
		end else begin
			off = AW'(count_q);
		end
	end

	assign sum  = {1'b0, head_q} + {1'b0, off};
	assign phys = (sum >= DEPTH_W) ? AW'(sum - DEPTH_W) : AW'(sum);

	assign ram_we    = (state_q == ST_CLEAR) || (take && item.req_type == cfrm_pkg::REQ_BYTE);
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_q : phys;
	assign ram_wdata = (state_q == ST_CLEAR) ? 8'h00 : item.rx_byte;

	cfrm_window_ram #(
		.DEPTH (BUF_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (phys),
		.rdata (ram_rdata)
	);

	assign last   = dat_v_s1 && (dat_idx_s1 == n_q - CW'(1));
	assign dig_hi = ram_rdata[7:4];
	assign dig_lo = ram_rdata[3:0];

	assign crc_good  = (crc_q == 16'h0000);
	assign err_frame = !mode_q && crc_good && (n_q == CW'(cfrm_pkg::ERR_FRAME)) && (b4_q == 8'h00);
	assign accept    = mode_q ? (crc_good && bcd_ok_q)
	                          : (crc_good && !err_frame && (b4_q == fn_q) && ({idh_q, idl_q} == id_q));

	always_comb begin
		done_nx = 1'b0;
		rsp_nx  = '0;
		case (state_q)
			ST_IDLE: begin
				done_nx = take && (item.req_type != cfrm_pkg::REQ_READ) &&
				          !((item.req_type == cfrm_pkg::REQ_BYTE) && need_scan);
			end
			ST_EVAL: begin
				done_nx = 1'b1;
				if (accept) begin
					rsp_nx.status    = cfrm_pkg::STAT_ACCEPT;
					rsp_nx.frame_len = 9'(n_q);
					if (mode_q) begin
						rsp_nx.meter_address = acc_q;
						rsp_nx.addr_word     = {b7_q, b6_q, b5_q, b4_q};
					end
				end else if (err_frame) begin
					rsp_nx.status     = cfrm_pkg::STAT_ERROR;
					rsp_nx.error_code = b6_q;
				end
			end
			ST_READ: begin
				done_nx          = 1'b1;
				rsp_nx.read_data = rd_ok_q ? ram_rdata : 8'h00;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			head_q     <= '0;
			clr_q      <= '0;
			count_q    <= '0;
			n_q        <= '0;
			iss_q      <= '0;
			mode_q     <= 1'b0;
			fn_q       <= '0;
			id_q       <= '0;
			crc_q      <= cfrm_pkg::CRC_INIT;
			b4_q       <= '0;
			b5_q       <= '0;
			b6_q       <= '0;
			b7_q       <= '0;
			idl_q      <= '0;
			idh_q      <= '0;
			acc_q      <= '0;
			bcd_ok_q   <= 1'b0;
			rd_ok_q    <= 1'b0;
			dat_v_s1   <= 1'b0;
			dat_idx_s1 <= '0;
			done_q     <= 1'b0;
			rsp_q      <= '0;
		end else begin
			done_q <= done_nx;
			if (done_nx) begin
				rsp_q <= rsp_nx;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_A) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (take) begin
						case (item.req_type)
							cfrm_pkg::REQ_ARM: begin
								count_q <= '0;
								mode_q  <= item.discovery_mode;
								fn_q    <= item.expected_fn;
								id_q    <= item.expected_id;
							end
							cfrm_pkg::REQ_BYTE: begin
								count_q <= n_new;
								n_q     <= n_new;
								if (full) begin
									head_q <= (head_q == LAST_A) ? '0 : head_q + AW'(1);
								end
								if (need_scan) begin
									state_q  <= ST_SCAN;
									iss_q    <= '0;
									crc_q    <= cfrm_pkg::CRC_INIT;
									acc_q    <= '0;
									bcd_ok_q <= 1'b1;
								end
							end
							cfrm_pkg::REQ_READ: begin
								rd_ok_q <= idx_ok;
								state_q <= ST_READ;
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (iss_q != n_q) begin
						iss_q      <= iss_q + CW'(1);
						dat_v_s1   <= 1'b1;
						dat_idx_s1 <= iss_q;
					end else begin
						dat_v_s1 <= 1'b0;
					end
					if (dat_v_s1) begin
						crc_q <= cfrm_pkg::crc16_byte(crc_q, ram_rdata);
						if (dat_idx_s1 == CW'(cfrm_pkg::FN_POS))      b4_q <= ram_rdata;
						if (dat_idx_s1 == CW'(cfrm_pkg::ADDR1_POS))   b5_q <= ram_rdata;
						if (dat_idx_s1 == CW'(cfrm_pkg::ERRCODE_POS)) b6_q <= ram_rdata;
						if (dat_idx_s1 == CW'(cfrm_pkg::ADDR3_POS))   b7_q <= ram_rdata;
						if (dat_idx_s1 == n_q - CW'(cfrm_pkg::ID_LO_BACK)) idl_q <= ram_rdata;
						if (dat_idx_s1 == n_q - CW'(cfrm_pkg::ID_HI_BACK)) idh_q <= ram_rdata;
						if (dat_idx_s1 >= CW'(cfrm_pkg::FN_POS) &&
						    dat_idx_s1 <= CW'(cfrm_pkg::ADDR3_POS)) begin
							acc_q <= 27'(acc_q * 27'd100) + 27'(27'(dig_hi) * 27'd10) + 27'(dig_lo);
							if (dig_hi > cfrm_pkg::BCD_MAX || dig_lo > cfrm_pkg::BCD_MAX) begin
								bcd_ok_q <= 1'b0;
							end
						end
					end
					if (last) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (accept) begin
						count_q <= '0;
					end
					state_q <= ST_IDLE;
				end
				ST_READ: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`CFRM_ASSERT_NXT(a_take_answers, take, done_q || busy, "accepted request neither answered nor busy")
	`CFRM_ASSERT_NXT(a_eval_done, state_q == ST_EVAL, done_q && state_q == ST_IDLE, "evaluation gave no result")
	`CFRM_ASSERT_IMP(a_accept_clears, done_q && rsp_q.status == cfrm_pkg::STAT_ACCEPT, count_q == '0, "count not cleared on accepted frame")
	`CFRM_ASSERT_IMP(a_data_in_scan, dat_v_s1, state_q == ST_SCAN, "window data outside scan")
	`CFRM_ASSERT_IMP(a_count_bound, state_q == ST_IDLE, count_q <= DEPTH_C, "byte count beyond window depth")

endmodule
